>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LAM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LAM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> hdl/lam_pkg.sv
// Types, constants and register codes of the longitudinal actuation monitor.
package lam_pkg;

  localparam int unsigned DATA_W      = 16;
  localparam int unsigned WINDOW_DEF  = 11;
  localparam int unsigned DELAY_DEF   = 5;

  // serial divider
  localparam int unsigned DIV_W       = 24;  // dividend magnitude
  localparam int unsigned DVS_W       = 16;  // divisor magnitude
  localparam int unsigned QUO_W       = 16;
  localparam int unsigned QS_LONG     = 16;  // quotient bits for a mean
  localparam int unsigned QS_SHORT    = 11;  // quotient bits for a ratio
  localparam int unsigned CNT_W       = $clog2(QS_LONG + 1);

  // ratio format
  localparam int unsigned RATIO_W     = 12;
  localparam int unsigned RATIO_FRAC  = 8;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 12'h100;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 12'h7ff;
  localparam logic [RATIO_W-1:0] RATIO_MIN = 12'h800;

  // stream and config port widths
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // register reset values
  localparam logic [15:0] ACCEL_LIMIT_RST    = 16'd768;
  localparam logic [15:0] FS_ACCEL_LIMIT_RST = 16'd384;
  localparam logic [14:0] FS_SPEED_LIMIT_RST = 15'd768;
  localparam logic [14:0] BRAKE_SPEED_RST    = 15'd768;
  localparam logic [15:0] BRAKE_CMD_RST      = 16'hff00;
  localparam logic [10:0] DECAY_RATIO_RST    = 11'd179;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_LIMIT    = 3'd0,
    CFG_FS_ACCEL_LIMIT = 3'd1,
    CFG_FS_SPEED_LIMIT = 3'd2,
    CFG_BRAKE_SPEED    = 3'd3,
    CFG_BRAKE_CMD      = 3'd4,
    CFG_DECAY_RATIO    = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_MEAS,
    S_RD_DCMD,
    S_RD_OCMD,
    S_UPDATE,
    S_MM_GO,
    S_MM_WAIT,
    S_CM_GO,
    S_CM_WAIT,
    S_EVAL,
    S_RT_GO,
    S_RT_WAIT,
    S_FIN
  } lam_state_e;

  typedef struct packed {
    logic             start;
    logic             short_div;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } lam_div_req_t;

  typedef struct packed {
    logic             busy;
    logic [QUO_W-1:0] quotient;
  } lam_div_rsp_t;

endpackage

>>> hdl/lam_ram.sv
// Generic simple dual-port RAM with registered read.
module lam_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lam_div.sv
// Bit-serial restoring divider on magnitudes, one quotient bit per cycle.
module lam_div
  import lam_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lam_div_req_t req_i,
  output lam_div_rsp_t rsp_o
);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] sh_q, sh_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, sh_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  // The caller guarantees the top dividend bits are below the divisor,
  // so only the low QS_* quotient bits are developed.
  always_comb begin
    rem_d = rem_q;
    sh_d  = sh_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    if (req_i.start) begin
      dvs_d = req_i.divisor;
      if (req_i.short_div) begin
        rem_d = DVS_W'(req_i.dividend >> QS_SHORT);
        sh_d  = req_i.dividend << (DIV_W - QS_SHORT);
        cnt_d = CNT_W'(QS_SHORT);
      end else begin
        rem_d = DVS_W'(req_i.dividend >> QS_LONG);
        sh_d  = req_i.dividend << (DIV_W - QS_LONG);
        cnt_d = CNT_W'(QS_LONG);
      end
    end else if (cnt_q != '0) begin
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      sh_d  = {sh_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = cnt_q != '0;
  assign rsp_o.quotient = sh_q[QUO_W-1:0];

endmodule

>>> hdl/longitudinal_actuation_monitor_core.sv
// Longitudinal actuation monitor: window means, abnormal flag and brake ratio.
//
//  channel | dir | handshake                     | beat
//  --------+-----+-------------------------------+------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | one tick of gear, flags, speed, accel
//  m_axis  | out | m_axis_tvalid / m_axis_tready | abnormal, brake ratio, weak brake
//  cfg     | in  | cfg_valid_i / cfg_ready_o     | register index and value
//
// An item with a gear mismatch or auto speed off skips the history and divider steps.
// Any other item makes three history reads on the single RAM read port, then runs the
// bit-serial divider for the two means (16 + 16 steps) and for a ratio when needed (11 steps).
// Reset clears the sums and the history fill count; history RAM is not swept.
// A finished result waits in the output register; the next item may be accepted meanwhile.
module longitudinal_actuation_monitor_core
  import lam_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WINDOW_DEF,
  parameter int unsigned DELAY_LEN  = DELAY_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // commanded_gear[3:0], actual_gear[7:4], auto_speed[8], free_space[9],
  // speed[25:10], accel_command[41:26], accel_measured[57:42], zero[63:58]
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // abnormal[0], brake_ratio[12:1], weak_brake[13], zero[15:14]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned CMD_LEN = WINDOW_LEN + DELAY_LEN;
  localparam int unsigned AW      = $clog2(CMD_LEN);
  localparam int unsigned FW      = $clog2(CMD_LEN + 1);
  localparam int unsigned SUM_W   = DATA_W + $clog2(WINDOW_LEN);
  localparam int unsigned MEM_W   = 2 * DATA_W;

  lam_state_e state_q, state_d;

  // configuration
  logic [15:0] acc_lim_q, fs_acc_lim_q, brake_cmd_q;
  logic [14:0] fs_spd_lim_q, brake_spd_q;
  logic [10:0] decay_q;

  // history bookkeeping
  logic [SUM_W-1:0] msum_q, csum_q;
  logic [AW-1:0]    wp_q;
  logic [FW-1:0]    fill_q;

  // item and intermediate values
  logic [DATA_W-1:0]  speed_q, acmd_q, ameas_q;
  logic               fs_q, zero_q;
  logic [DATA_W-1:0]  meas_old_q, dcmd_q;
  logic [DATA_W-1:0]  mmean_q, cmean_q;
  logic               abn_q;
  logic [RATIO_W-1:0] ratio_q;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  // RAM
  logic             mem_we;
  logic [AW-1:0]    mem_raddr;
  logic [MEM_W-1:0] mem_rdata;

  lam_div_req_t div_req;
  lam_div_rsp_t div_rsp;

  // input decode
  logic in_acc, in_zero;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_zero = (s_axis_tdata[3:0] != s_axis_tdata[7:4]) || !s_axis_tdata[8];

  // addresses of the entries written WINDOW_LEN (addr_w) and DELAY_LEN (addr_d) ticks back
  logic [AW:0]   addr_w_sum, addr_d_sum;
  logic [AW-1:0] addr_w, addr_d;
  assign addr_w_sum = {1'b0, wp_q} + (AW + 1)'(DELAY_LEN);
  assign addr_d_sum = {1'b0, wp_q} + (AW + 1)'(WINDOW_LEN);
  assign addr_w = (addr_w_sum >= (AW + 1)'(CMD_LEN)) ? AW'(addr_w_sum - (AW + 1)'(CMD_LEN))
                                                     : AW'(addr_w_sum);
  assign addr_d = (addr_d_sum >= (AW + 1)'(CMD_LEN)) ? AW'(addr_d_sum - (AW + 1)'(CMD_LEN))
                                                     : AW'(addr_d_sum);

  // entries older than the fill count read as zero
  logic          meas_old_ok, dcmd_ok, ocmd_ok;
  logic [DATA_W-1:0] ocmd;
  assign meas_old_ok = fill_q >= FW'(WINDOW_LEN);
  assign dcmd_ok     = fill_q >= FW'(DELAY_LEN);
  assign ocmd_ok     = fill_q == FW'(CMD_LEN);
  assign ocmd        = ocmd_ok ? mem_rdata[MEM_W-1:DATA_W] : '0;

  // sum magnitudes and signs
  logic [SUM_W-1:0] msum_mag, csum_mag;
  assign msum_mag = msum_q[SUM_W-1] ? (~msum_q + 1'b1) : msum_q;
  assign csum_mag = csum_q[SUM_W-1] ? (~csum_q + 1'b1) : csum_q;

  logic [QUO_W-1:0]   q_neg;
  logic [RATIO_W-1:0] q12, q12_neg;
  assign q_neg   = ~div_rsp.quotient + 1'b1;
  assign q12     = div_rsp.quotient[RATIO_W-1:0];
  assign q12_neg = ~q12 + 1'b1;

  // evaluation on the two means
  logic [DATA_W-1:0] spd_mag, mmag, cmag;
  logic              need_ratio, cmd_zero, sat_big, ratio_neg, abn_now;
  assign spd_mag    = speed_q[DATA_W-1] ? (~speed_q + 1'b1) : speed_q;
  assign mmag       = mmean_q[DATA_W-1] ? (~mmean_q + 1'b1) : mmean_q;
  assign cmag       = cmean_q[DATA_W-1] ? (~cmean_q + 1'b1) : cmean_q;
  assign need_ratio = (spd_mag > {1'b0, brake_spd_q}) &&
                      ($signed(cmean_q) < $signed(brake_cmd_q));
  assign cmd_zero   = cmean_q == '0;
  // quotient magnitude of at least 2048 saturates without dividing
  assign sat_big    = {3'b000, mmag} >= {cmag, 3'b000};
  assign ratio_neg  = mmean_q[DATA_W-1] ^ cmean_q[DATA_W-1];
  assign abn_now    = ($signed(mmean_q) >= $signed(acc_lim_q)) ||
                      (fs_q && (($signed(mmean_q) >= $signed(fs_acc_lim_q)) ||
                                (spd_mag >= {1'b0, fs_spd_lim_q})));

  logic out_free, out_load, weak_now;
  assign out_free = !out_valid_q || m_axis_tready;
  assign weak_now = !zero_q &&
                    ($signed({ratio_q[RATIO_W-1], ratio_q}) < $signed({2'b00, decay_q}));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_acc) state_d = in_zero ? S_FIN : S_RD_MEAS;
      S_RD_MEAS: state_d = S_RD_DCMD;
      S_RD_DCMD: state_d = S_RD_OCMD;
      S_RD_OCMD: state_d = S_UPDATE;
      S_UPDATE:  state_d = S_MM_GO;
      S_MM_GO:   state_d = S_MM_WAIT;
      S_MM_WAIT: if (!div_rsp.busy) state_d = S_CM_GO;
      S_CM_GO:   state_d = S_CM_WAIT;
      S_CM_WAIT: if (!div_rsp.busy) state_d = S_EVAL;
      S_EVAL:    state_d = (need_ratio && !cmd_zero && !sat_big) ? S_RT_GO : S_FIN;
      S_RT_GO:   state_d = S_RT_WAIT;
      S_RT_WAIT: if (!div_rsp.busy) state_d = S_FIN;
      S_FIN:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready     = 1'b0;
    mem_raddr         = wp_q;
    mem_we            = 1'b0;
    out_load          = 1'b0;
    div_req.start     = 1'b0;
    div_req.short_div = 1'b0;
    div_req.dividend  = DIV_W'(msum_mag);
    div_req.divisor   = DVS_W'(WINDOW_LEN);
    unique case (state_q)
      S_IDLE:    s_axis_tready = 1'b1;
      S_RD_MEAS: mem_raddr = addr_w;
      S_RD_DCMD: mem_raddr = addr_d;
      S_UPDATE:  mem_we = 1'b1;
      S_MM_GO:   div_req.start = 1'b1;
      S_CM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(csum_mag);
      end
      S_RT_GO: begin
        div_req.start     = 1'b1;
        div_req.short_div = 1'b1;
        div_req.dividend  = DIV_W'({mmag, {RATIO_FRAC{1'b0}}});
        div_req.divisor   = cmag;
      end
      S_FIN:     out_load = out_free;
      default: ;
    endcase
  end

  lam_ram #(
    .WIDTH (MEM_W),
    .DEPTH (CMD_LEN)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i ({acmd_q, ameas_q}),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lam_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // control state, configuration and history bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      acc_lim_q    <= ACCEL_LIMIT_RST;
      fs_acc_lim_q <= FS_ACCEL_LIMIT_RST;
      fs_spd_lim_q <= FS_SPEED_LIMIT_RST;
      brake_spd_q  <= BRAKE_SPEED_RST;
      brake_cmd_q  <= BRAKE_CMD_RST;
      decay_q      <= DECAY_RATIO_RST;
      msum_q       <= '0;
      csum_q       <= '0;
      wp_q         <= '0;
      fill_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ACCEL_LIMIT:    acc_lim_q    <= cfg_data_i;
          CFG_FS_ACCEL_LIMIT: fs_acc_lim_q <= cfg_data_i;
          CFG_FS_SPEED_LIMIT: fs_spd_lim_q <= cfg_data_i[14:0];
          CFG_BRAKE_SPEED:    brake_spd_q  <= cfg_data_i[14:0];
          CFG_BRAKE_CMD:      brake_cmd_q  <= cfg_data_i;
          CFG_DECAY_RATIO:    decay_q      <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (in_acc && in_zero) begin
        msum_q <= '0;
        csum_q <= '0;
        fill_q <= '0;
      end
      if (state_q == S_UPDATE) begin
        msum_q <= msum_q + SUM_W'($signed(ameas_q)) - SUM_W'($signed(meas_old_q));
        csum_q <= csum_q + SUM_W'($signed(dcmd_q)) - SUM_W'($signed(ocmd));
        wp_q   <= (wp_q == AW'(CMD_LEN - 1)) ? '0 : wp_q + 1'b1;
        if (!ocmd_ok) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fs_q    <= s_axis_tdata[9];
      speed_q <= s_axis_tdata[25:10];
      acmd_q  <= s_axis_tdata[41:26];
      ameas_q <= s_axis_tdata[57:42];
      zero_q  <= in_zero;
      abn_q   <= 1'b0;
      ratio_q <= '0;
    end
    if (state_q == S_RD_DCMD) begin
      meas_old_q <= meas_old_ok ? mem_rdata[DATA_W-1:0] : '0;
    end
    if (state_q == S_RD_OCMD) begin
      dcmd_q <= dcmd_ok ? mem_rdata[MEM_W-1:DATA_W] : '0;
    end
    if (state_q == S_MM_WAIT && !div_rsp.busy) begin
      mmean_q <= msum_q[SUM_W-1] ? q_neg : div_rsp.quotient;
    end
    if (state_q == S_CM_WAIT && !div_rsp.busy) begin
      cmean_q <= csum_q[SUM_W-1] ? q_neg : div_rsp.quotient;
    end
    if (state_q == S_EVAL) begin
      abn_q <= abn_now;
      if (!need_ratio) begin
        ratio_q <= RATIO_ONE;
      end else if (cmd_zero) begin
        // sign of the measured mean alone
        if (mmean_q == '0) begin
          ratio_q <= '0;
        end else begin
          ratio_q <= mmean_q[DATA_W-1] ? RATIO_MIN : RATIO_MAX;
        end
      end else if (sat_big) begin
        ratio_q <= ratio_neg ? RATIO_MIN : RATIO_MAX;
      end
    end
    if (state_q == S_RT_WAIT && !div_rsp.busy) begin
      ratio_q <= ratio_neg ? q12_neg : q12;
    end
    if (out_load) begin
      out_data_q <= {2'b00, weak_now, ratio_q, abn_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

endmodule

>>> hdl/lam_checker.sv
// Port-level checks of the longitudinal actuation monitor, bound to the core.
`include "assert_macros.svh"

module lam_checker
  import lam_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result beat stays up
  `LAM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // and keeps its payload
  `LAM_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // one item at a time: input closes right after a beat is taken
  `LAM_ASSERT_NXT(a_in_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a ratio saturated high can never be under the decay threshold
  `LAM_ASSERT_IMP(a_weak_sat, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[13], m_axis_tdata[12:1] != RATIO_MAX)

endmodule

bind longitudinal_actuation_monitor_core lam_checker u_lam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
